@@ rtl/b64d_pkg.sv @@
package b64d_pkg;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_LENGTH = 2'd1;
  localparam logic [1:0] ST_BAD_PAD    = 2'd2;
  localparam logic [1:0] ST_BAD_CHAR   = 2'd3;

  // symbol codes beside the 64 sextets
  localparam logic [6:0] SYM_PAD = 7'd64;
  localparam logic [6:0] SYM_BAD = 7'd65;

  // alphabet bounds and offsets
  localparam logic [7:0] CH_UPPER_LO = 8'h41;
  localparam logic [7:0] CH_UPPER_HI = 8'h5A;
  localparam logic [7:0] CH_LOWER_LO = 8'h61;
  localparam logic [7:0] CH_LOWER_HI = 8'h7A;
  localparam logic [7:0] LOWER_OFS   = 8'h47;
  localparam logic [7:0] CH_DIGIT_LO = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI = 8'h39;
  localparam logic [7:0] DIGIT_OFS   = 8'h04;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_PAD      = 8'h3D;
  localparam logic [6:0] SEXT_PLUS   = 7'h3E;
  localparam logic [6:0] SEXT_SLASH  = 7'h3F;

  // result queue geometry
  localparam int RES_DEPTH = 8;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);
  localparam int MAX_RES   = 3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic [1:0] status;
    logic       end_of_message;
  } result_t;

  // character to sextet, pad or bad
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c inside {[CH_UPPER_LO:CH_UPPER_HI]}) begin
      d = c - CH_UPPER_LO;
      return d[6:0];
    end
    if (c inside {[CH_LOWER_LO:CH_LOWER_HI]}) begin
      d = c - LOWER_OFS;
      return d[6:0];
    end
    if (c inside {[CH_DIGIT_LO:CH_DIGIT_HI]}) begin
      d = c + DIGIT_OFS;
      return d[6:0];
    end
    if (c == CH_PLUS)  return SEXT_PLUS;
    if (c == CH_SLASH) return SEXT_SLASH;
    if (c == CH_PAD)   return SYM_PAD;
    return SYM_BAD;
  endfunction

endpackage

@@ rtl/b64d_if.sv @@
// character channel
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

// decoded result channel
interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic [1:0] status;
  logic       end_of_message;

  modport source (output valid, output out_byte, output has_byte, output status,
                  output end_of_message, input ready);
  modport sink   (input valid, input out_byte, input has_byte, input status,
                  input end_of_message, output ready);
endinterface

@@ rtl/base64_stream_decoder.sv @@
// channel   | dir | payload                                   | handshake
// in_ch     | in  | in_char[7:0], in_last                     | valid / ready
// out_ch    | out | out_byte[7:0], has_byte, status[1:0], eom | valid / ready
//
// one character word is taken per cycle unless decode stalls; the decode stage
// decodes it combinationally and writes its zero to three results into an
// 8-entry result queue that feeds an output register; at best the first result
// of an accepted character passes just the input and output registers; the queue
// drains one result word per cycle while out_ch.ready is high; decode stalls only
// when the words of the character it holds do not fit in the queue
// rst_n is synchronous, active low, and clears all control and decoder state
module base64_stream_decoder (
  input  logic              clk,
  input  logic              rst_n,
  b64d_in_if.sink           in_ch,
  b64d_out_if.source        out_ch
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;
  logic       s1_fire;

  // decoder state
  logic [17:0] acc_r, acc_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        pad_r, pad_nxt;
  logic [1:0]  err_r, err_nxt;
  logic        done_r;

  // result queue and output register
  b64d_pkg::result_t                      res_mem_r [b64d_pkg::RES_DEPTH];
  logic [b64d_pkg::RES_PTR_W-1:0]         wr_ptr_r, rd_ptr_r;
  logic [b64d_pkg::RES_CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                                   pop;
  logic                                   out_valid_r;
  b64d_pkg::result_t                      out_data_r;
  logic                                   head_free;
  logic                                   head_from_mem;
  logic                                   head_from_new;
  logic [1:0]                             n_mem_wr;

  // decode outputs
  b64d_pkg::result_t res [b64d_pkg::MAX_RES];
  logic [1:0]        n_res;
  logic [7:0]        byte0, byte1, byte2;
  logic [1:0]        n_bytes;
  logic [6:0]        sext;
  logic [23:0]       word24;
  logic [1:0]        status;
  logic              fits;

  // input handshake
  assign in_ch.ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      s1_char_r <= in_ch.in_char;
      s1_last_r <= in_ch.in_last;
    end
  end

  // decode one character
  always_comb begin
    acc_nxt = acc_r;
    pad_nxt = pad_r;
    err_nxt = err_r;
    byte0   = 8'd0;
    byte1   = 8'd0;
    byte2   = 8'd0;
    n_bytes = 2'd0;
    sext    = b64d_pkg::sextet_of(s1_char_r);
    word24  = {acc_r, sext[5:0]};
    if (pad_r) begin
      // character after a third-position pad
      if (s1_last_r) begin
        if (err_r == b64d_pkg::ST_OK) begin
          byte0   = acc_r[11:4];
          n_bytes = 2'd1;
        end
      end else if (err_nxt == b64d_pkg::ST_OK) begin
        err_nxt = b64d_pkg::ST_BAD_PAD;
      end
      pad_nxt = 1'b0;
    end else if (sext < b64d_pkg::SYM_PAD) begin
      if (err_r == b64d_pkg::ST_OK) begin
        if (pos_r == 2'd3) begin
          byte0   = word24[23:16];
          byte1   = word24[15:8];
          byte2   = word24[7:0];
          n_bytes = 2'd3;
          acc_nxt = 18'd0;
        end else begin
          acc_nxt = word24[17:0];
        end
      end
    end else if (sext == b64d_pkg::SYM_PAD) begin
      if (pos_r == 2'd3 && s1_last_r) begin
        if (err_r == b64d_pkg::ST_OK) begin
          byte0   = acc_r[17:10];
          byte1   = acc_r[9:2];
          n_bytes = 2'd2;
        end
      end else if (pos_r == 2'd2) begin
        pad_nxt = 1'b1;
      end else if (err_nxt == b64d_pkg::ST_OK) begin
        err_nxt = b64d_pkg::ST_BAD_PAD;
      end
    end else if (err_nxt == b64d_pkg::ST_OK) begin
      err_nxt = b64d_pkg::ST_BAD_CHAR;
    end
    pos_nxt = pos_r + 2'd1;

    // final status, bad length first
    status = (pos_nxt != 2'd0) ? b64d_pkg::ST_BAD_LENGTH : err_nxt;
    if (s1_last_r && status != b64d_pkg::ST_OK) begin
      n_bytes = 2'd0;
    end

    res[0] = '{out_byte: byte0, has_byte: 1'b1, status: b64d_pkg::ST_OK,
               end_of_message: 1'b0};
    res[1] = '{out_byte: byte1, has_byte: 1'b1, status: b64d_pkg::ST_OK,
               end_of_message: 1'b0};
    res[2] = '{out_byte: byte2, has_byte: 1'b1, status: b64d_pkg::ST_OK,
               end_of_message: 1'b0};
    n_res  = n_bytes;
    if (s1_last_r) begin
      if (n_bytes == 2'd0) begin
        res[0] = '{out_byte: 8'd0, has_byte: 1'b0, status: status,
                   end_of_message: 1'b1};
        n_res  = 2'd1;
      end else begin
        res[n_bytes - 2'd1].status         = status;
        res[n_bytes - 2'd1].end_of_message = 1'b1;
      end
    end
  end

  // commit when the words fit in the queue
  assign fits    = cnt_r <= (b64d_pkg::RES_CNT_W'(b64d_pkg::RES_DEPTH)
                             - b64d_pkg::RES_CNT_W'(n_res));
  assign s1_fire = s1_valid_r && fits;

  // decoder state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= 18'd0;
      pos_r  <= 2'd0;
      pad_r  <= 1'b0;
      err_r  <= b64d_pkg::ST_OK;
      done_r <= 1'b0;
    end else if (s1_fire) begin
      if (s1_last_r) begin
        acc_r  <= 18'd0;
        pos_r  <= 2'd0;
        pad_r  <= 1'b0;
        err_r  <= b64d_pkg::ST_OK;
        done_r <= 1'b1;
      end else begin
        acc_r  <= acc_nxt;
        pos_r  <= pos_nxt;
        pad_r  <= pad_nxt;
        err_r  <= err_nxt;
        done_r <= 1'b0;
      end
    end
  end

  // output register takes the oldest queued word, else the first new word
  assign pop           = out_ch.valid && out_ch.ready;
  assign head_free     = !out_valid_r || pop;
  assign head_from_mem = head_free && (cnt_r != '0);
  assign head_from_new = head_free && (cnt_r == '0) && s1_fire && (n_res != 2'd0);
  assign n_mem_wr      = s1_fire ? (n_res - {1'b0, head_from_new}) : 2'd0;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_byte       = out_data_r.out_byte;
  assign out_ch.has_byte       = out_data_r.has_byte;
  assign out_ch.status         = out_data_r.status;
  assign out_ch.end_of_message = out_data_r.end_of_message;

  always_comb begin
    cnt_nxt = cnt_r + b64d_pkg::RES_CNT_W'(n_mem_wr)
              - b64d_pkg::RES_CNT_W'(head_from_mem);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (s1_fire)       wr_ptr_r <= wr_ptr_r + b64d_pkg::RES_PTR_W'(n_mem_wr);
      if (head_from_mem) rd_ptr_r <= rd_ptr_r + b64d_pkg::RES_PTR_W'(1);
      if (head_free)     out_valid_r <= head_from_mem || head_from_new;
    end
  end

  // queue read into the output register
  always_ff @(posedge clk) begin
    if (head_from_mem) begin
      out_data_r <= res_mem_r[rd_ptr_r];
    end else if (head_from_new) begin
      out_data_r <= res[0];
    end
  end

  // queue write, skipping the word that went straight to the output
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      for (int k = 0; k < b64d_pkg::MAX_RES; k++) begin
        if (k >= int'(head_from_new) && k < int'(n_res)) begin
          res_mem_r[wr_ptr_r + b64d_pkg::RES_PTR_W'(k - int'(head_from_new))] <= res[k];
        end
      end
    end
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= b64d_pkg::RES_CNT_W'(b64d_pkg::RES_DEPTH))
    else $error("result queue count over depth");

  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (pos_r == 2'd0 && !pad_r && err_r == b64d_pkg::ST_OK && acc_r == 18'd0))
    else $error("state not cleared after message end");

  a_err_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.end_of_message && out_ch.status != b64d_pkg::ST_OK)
      |-> !out_ch.has_byte)
    else $error("byte delivered with failing status");

  a_pad_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && pad_r && !s1_last_r) |=> (err_r != b64d_pkg::ST_OK))
    else $error("character after third-position pad did not latch an error");

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && cnt_r == '0) |-> s1_fire)
    else $error("decode stage stalled on an empty queue");

endmodule

@@ test/base64_stream_decoder_tb.sv @@
`timescale 1ns / 1ps

module base64_stream_decoder_tb;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_AFTER = 100;
  localparam int HOLD_LEN   = 60;
  localparam int CHAR_TOTAL = 265;

  typedef logic [7:0] text_t[$];

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  b64d_in_if  in_if ();
  b64d_out_if out_if ();

  base64_stream_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #2 clk = ~clk;

  // decoder shadow state
  logic [17:0] quantum_acc = '0;
  logic [1:0]  char_pos    = '0;
  logic        pad_seen    = 1'b0;
  logic [1:0]  err_code    = b64d_pkg::ST_OK;

  char_word_t          char_q[$];
  b64d_pkg::result_t   decoded_q[$];
  char_word_t          held;

  int send_gap = 0;
  int send_calm = 0;
  int recv_calm = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic recv_holding = 1'b0;
  int results_seen = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;

  // mostly short gaps, a few long ones, and stretches without any
  function automatic int pick_gap(inout int calm_left);
    int dice;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    dice = $urandom_range(0, 99);
    if (dice < 6) begin
      calm_left = $urandom_range(15, 60);
      return 0;
    end
    if (dice < 60) return 0;
    if (dice < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ascii code to 6-bit value, or pad / bad marker
  function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
    logic [7:0] val;
    val = '0;
    if (c >= b64d_pkg::CH_UPPER_LO && c <= b64d_pkg::CH_UPPER_HI)
      val = c - b64d_pkg::CH_UPPER_LO;
    else if (c >= b64d_pkg::CH_LOWER_LO && c <= b64d_pkg::CH_LOWER_HI)
      val = c - b64d_pkg::CH_LOWER_LO + 8'd26;
    else if (c >= b64d_pkg::CH_DIGIT_LO && c <= b64d_pkg::CH_DIGIT_HI)
      val = c - b64d_pkg::CH_DIGIT_LO + 8'd52;
    else if (c == b64d_pkg::CH_PLUS) return b64d_pkg::SEXT_PLUS;
    else if (c == b64d_pkg::CH_SLASH) return b64d_pkg::SEXT_SLASH;
    else if (c == b64d_pkg::CH_PAD) return b64d_pkg::SYM_PAD;
    else return b64d_pkg::SYM_BAD;
    return val[6:0];
  endfunction

  // 6-bit value to alphabet character
  function automatic logic [7:0] sextet_char(input logic [5:0] s);
    if (s < 6'd26) return b64d_pkg::CH_UPPER_LO + 8'(s);
    if (s < 6'd52) return b64d_pkg::CH_LOWER_LO + 8'(s - 6'd26);
    if (s < 6'd62) return b64d_pkg::CH_DIGIT_LO + 8'(s - 6'd52);
    if (s == 6'd62) return b64d_pkg::CH_PLUS;
    return b64d_pkg::CH_SLASH;
  endfunction

  function automatic text_t to_text(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.insert(t.size(), s[i]);
    return t;
  endfunction

  // random payload encoded as text, sometimes with a junk final character after a single "="
  function automatic text_t encode_random(input int nbytes);
    text_t t;
    logic [23:0] grp;
    int left;
    left = nbytes;
    while (left > 0) begin
      grp = 24'($urandom);
      t.insert(t.size(), sextet_char(grp[23:18]));
      t.insert(t.size(), sextet_char(grp[17:12]));
      if (left >= 2) t.insert(t.size(), sextet_char(grp[11:6]));
      else t.insert(t.size(), b64d_pkg::CH_PAD);
      if (left >= 3) t.insert(t.size(), sextet_char(grp[5:0]));
      else if (left == 1 && $urandom_range(0, 3) == 0)
        t.insert(t.size(), 8'($urandom_range(0, 255)));
      else t.insert(t.size(), b64d_pkg::CH_PAD);
      left -= 3;
    end
    return t;
  endfunction

  task automatic queue_text(input text_t t);
    char_word_t w;
    for (int i = 0; i < t.size(); i++) begin
      w.ch = t[i];
      w.last = (i == t.size() - 1);
      char_q.insert(char_q.size(), w);
    end
  endtask

  task automatic note_error(input logic [1:0] code);
    if (err_code == b64d_pkg::ST_OK) err_code = code;
  endtask

  // decode one accepted character and queue the words it should produce
  task automatic decode_char(input logic [7:0] c, input logic last);
    logic [7:0] bytes[3];
    logic [6:0] sym;
    logic [23:0] wide;
    logic [1:0] stat;
    b64d_pkg::result_t r;
    int n;
    n = 0;
    stat = b64d_pkg::ST_OK;
    if (pad_seen) begin
      if (last) begin
        if (err_code == b64d_pkg::ST_OK) begin
          bytes[0] = quantum_acc[11:4];
          n = 1;
        end
      end else begin
        note_error(b64d_pkg::ST_BAD_PAD);
      end
      pad_seen = 1'b0;
    end else begin
      sym = char_to_sextet(c);
      if (sym < b64d_pkg::SYM_PAD) begin
        if (err_code == b64d_pkg::ST_OK) begin
          wide = {quantum_acc, sym[5:0]};
          if (char_pos == 2'd3) begin
            bytes[0] = wide[23:16];
            bytes[1] = wide[15:8];
            bytes[2] = wide[7:0];
            n = 3;
            quantum_acc = '0;
          end else begin
            quantum_acc = wide[17:0];
          end
        end
      end else if (sym == b64d_pkg::SYM_PAD) begin
        if (char_pos == 2'd3 && last) begin
          if (err_code == b64d_pkg::ST_OK) begin
            bytes[0] = quantum_acc[17:10];
            bytes[1] = quantum_acc[9:2];
            n = 2;
          end
        end else if (char_pos == 2'd2) begin
          pad_seen = 1'b1;
        end else begin
          note_error(b64d_pkg::ST_BAD_PAD);
        end
      end else begin
        note_error(b64d_pkg::ST_BAD_CHAR);
      end
    end
    char_pos = char_pos + 2'd1;

    // length check wins over the latched error; any error drops the bytes
    if (last) begin
      stat = (char_pos != 2'd0) ? b64d_pkg::ST_BAD_LENGTH : err_code;
      if (stat != b64d_pkg::ST_OK) n = 0;
    end

    if (last && n == 0) begin
      r = '{out_byte: 8'd0, has_byte: 1'b0, status: stat, end_of_message: 1'b1};
      decoded_q.insert(decoded_q.size(), r);
    end else begin
      for (int k = 0; k < n; k++) begin
        r.out_byte = bytes[k];
        r.has_byte = 1'b1;
        r.end_of_message = last && (k == n - 1);
        r.status = r.end_of_message ? stat : b64d_pkg::ST_OK;
        decoded_q.insert(decoded_q.size(), r);
      end
    end

    if (last) begin
      quantum_acc = '0;
      char_pos = '0;
      pad_seen = 1'b0;
      err_code = b64d_pkg::ST_OK;
    end
  endtask

  // character driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.in_char <= '0;
      in_if.in_last <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) decode_char(held.ch, held.last);
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0 && !recv_holding) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (char_q.size() > 0) begin
          held = char_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.in_char <= held.ch;
          in_if.in_last <= held.last;
          send_gap = pick_gap(send_calm);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    b64d_pkg::result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      recv_holding <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (decoded_q.size() == 0) begin
          $error("result word with nothing expected: out_byte %0h", out_if.out_byte);
          mismatch_count++;
        end else begin
          want = decoded_q.pop_front();
          if (out_if.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_if.out_byte);
            mismatch_count++;
          end
          if (out_if.has_byte !== want.has_byte) begin
            $error("has_byte: expected %0b, got %0b", want.has_byte, out_if.has_byte);
            mismatch_count++;
          end
          if (out_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_if.status);
            mismatch_count++;
          end
          if (out_if.end_of_message !== want.end_of_message) begin
            $error("end_of_message: expected %0b, got %0b", want.end_of_message,
                   out_if.end_of_message);
            mismatch_count++;
          end
        end
      end

      // one long hold-off so the result queue fills and the input backs up
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end else if (stall_left > 0) begin
        stall_left--;
      end else begin
        stall_left = pick_gap(recv_calm);
      end
      out_if.ready <= (hold_left == 0) && (stall_left == 0);
      recv_holding <= (hold_left > 0);
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    text_t txt;
    int pick;
    int pos;
    in_if.valid = 1'b0;
    in_if.in_char = '0;
    in_if.in_last = 1'b0;
    out_if.ready = 1'b0;

    // full alphabet extremes, six bytes
    queue_text(to_text("AZaz09+/"));
    // two-byte close
    queue_text(to_text("TWE="));
    // one-byte close, final character ignored
    txt = to_text("TQ=?");
    txt[3] = 8'hFF;
    queue_text(txt);
    // bad character kept over the later pad
    txt = to_text("A?=A");
    txt[1] = 8'h00;
    queue_text(txt);
    // pad in second position with odd length
    queue_text(to_text("A=B"));
    // character after third-position pad that is not last
    queue_text(to_text("AA=BA"));
    // pad first, bad pad status
    queue_text(to_text("=AAA"));

    // random messages: mostly well-formed, some broken, some noise
    while (char_q.size() < CHAR_TOTAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        txt = {};
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 3) == 0) txt.insert(txt.size(), b64d_pkg::CH_PAD);
          else txt.insert(txt.size(), 8'($urandom_range(0, 255)));
        end
      end else begin
        if ($urandom_range(0, 9) == 0) txt = encode_random($urandom_range(13, 40));
        else txt = encode_random($urandom_range(1, 12));
        if (pick < 25) begin
          pos = $urandom_range(0, txt.size() - 1);
          case ($urandom_range(0, 3))
            0: txt[pos] = 8'($urandom_range(0, 255));
            1: txt[pos] = b64d_pkg::CH_PAD;
            2: if (txt.size() > 1) txt.delete(pos);
            default: txt.insert(pos, sextet_char(6'($urandom)));
          endcase
        end
      end
      queue_text(txt);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (char_q.size() != 0 || in_if.valid || decoded_q.size() != 0);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0 && decoded_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ base64_stream_decoder.f @@
rtl/b64d_pkg.sv
rtl/b64d_if.sv
rtl/base64_stream_decoder.sv
test/base64_stream_decoder_tb.sv
